### rtl/netlist_text_tokenizer_assert.svh
// ----------------------------------------------------------------------------
// Netlist text tokenizer assertion macros
// Concurrent assertion wrappers; NO_ASSERTIONS compiles them away.
// ----------------------------------------------------------------------------
`ifndef NETLIST_TEXT_TOKENIZER_ASSERT_SVH
`define NETLIST_TEXT_TOKENIZER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// prop holds at every clock outside reset
`define NTT_ASSERT(name, clk, rstn, prop) \
    name: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("netlist_text_tokenizer assertion failed");
// ante implies cons in the next cycle
`define NTT_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("netlist_text_tokenizer assertion failed");
`else
`define NTT_ASSERT(name, clk, rstn, prop)
`define NTT_ASSERT_NEXT(name, clk, rstn, ante, cons)
`endif

`endif

### rtl/ntt_pkg.sv
// ----------------------------------------------------------------------------
// Netlist text tokenizer package
// Scanner states, token kinds, character codes and the result bundle type.
// ----------------------------------------------------------------------------
`default_nettype none

package ntt_pkg;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_WORD  = 3'd1,
        ST_HASH  = 3'd2,
        ST_BLK   = 3'd3,
        ST_STAR  = 3'd4,
        ST_BSL   = 3'd5,
        ST_SLASH = 3'd6
    } state_t;

    typedef enum logic [2:0] {
        KIND_BYTE = 3'd0,
        KIND_END  = 3'd1,
        KIND_NL   = 3'd2,
        KIND_EQ   = 3'd3,
        KIND_EOF  = 3'd4
    } kind_t;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_BSL   = 8'h5C;

    localparam int MAX_RES = 3;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] word_byte;
        logic       dot_word;
    } result_t;

    // all tokens caused by one input byte, in order
    typedef struct packed {
        result_t [MAX_RES-1:0] res;
        logic    [1:0]         cnt;
    } bundle_t;

endpackage

`default_nettype wire

### rtl/ntt_step.sv
// ----------------------------------------------------------------------------
// Netlist text tokenizer step logic
// Next scanner state and the token bundle for one input byte.
// ----------------------------------------------------------------------------
`default_nettype none

module ntt_step (
    input  wire ntt_pkg::state_t  state,
    input  wire logic             dot,
    input  wire logic [7:0]       char_in,
    input  wire logic             end_of_input,
    output ntt_pkg::state_t       state_next,
    output logic                  dot_next,
    output ntt_pkg::bundle_t      bundle
);

    function automatic ntt_pkg::result_t mk(ntt_pkg::kind_t k, logic [7:0] b, logic d);
        ntt_pkg::result_t r;
        r.kind      = k;
        r.word_byte = b;
        r.dot_word  = d;
        return r;
    endfunction

    logic ender;

    assign ender = end_of_input
                || char_in == ntt_pkg::CH_SPACE || char_in == ntt_pkg::CH_TAB
                || char_in == ntt_pkg::CH_NL    || char_in == ntt_pkg::CH_EQ
                || char_in == ntt_pkg::CH_HASH  || char_in == ntt_pkg::CH_BSL;

    always_comb begin
        logic [1:0] n;
        logic       do_idle;
        n          = 2'd0;
        do_idle    = 1'b0;
        state_next = state;
        dot_next   = dot;
        bundle     = '0;

        unique case (state)
            ntt_pkg::ST_WORD: begin
                if (ender) begin
                    bundle.res[n] = mk(ntt_pkg::KIND_END, 8'h00, dot);
                    n = n + 2'd1;
                    dot_next = 1'b0;
                    do_idle  = 1'b1;
                end else begin
                    bundle.res[n] = mk(ntt_pkg::KIND_BYTE, char_in, 1'b0);
                    n = n + 2'd1;
                end
            end
            ntt_pkg::ST_HASH: begin
                if (end_of_input) begin
                    bundle.res[n] = mk(ntt_pkg::KIND_EOF, 8'h00, 1'b0);
                    n = n + 2'd1;
                    state_next = ntt_pkg::ST_IDLE;
                end else if (char_in == ntt_pkg::CH_NL) begin
                    bundle.res[n] = mk(ntt_pkg::KIND_NL, 8'h00, 1'b0);
                    n = n + 2'd1;
                    state_next = ntt_pkg::ST_IDLE;
                end
            end
            ntt_pkg::ST_BLK: begin
                if (end_of_input) begin
                    bundle.res[n] = mk(ntt_pkg::KIND_EOF, 8'h00, 1'b0);
                    n = n + 2'd1;
                    state_next = ntt_pkg::ST_IDLE;
                end else if (char_in == ntt_pkg::CH_STAR) begin
                    state_next = ntt_pkg::ST_STAR;
                end
            end
            ntt_pkg::ST_STAR: begin
                if (end_of_input) begin
                    bundle.res[n] = mk(ntt_pkg::KIND_EOF, 8'h00, 1'b0);
                    n = n + 2'd1;
                    state_next = ntt_pkg::ST_IDLE;
                end else if (char_in == ntt_pkg::CH_SLASH) begin
                    state_next = ntt_pkg::ST_IDLE;
                end else if (char_in != ntt_pkg::CH_STAR) begin
                    state_next = ntt_pkg::ST_BLK;
                end
            end
            ntt_pkg::ST_BSL: begin
                if (end_of_input) begin
                    // empty word closed before end of file
                    bundle.res[n] = mk(ntt_pkg::KIND_END, 8'h00, dot);
                    n = n + 2'd1;
                    dot_next = 1'b0;
                    do_idle  = 1'b1;
                end else if (char_in == ntt_pkg::CH_NL) begin
                    state_next = ntt_pkg::ST_IDLE;
                end else begin
                    bundle.res[n] = mk(ntt_pkg::KIND_BYTE, char_in, 1'b0);
                    n = n + 2'd1;
                    state_next = ntt_pkg::ST_WORD;
                end
            end
            ntt_pkg::ST_SLASH: begin
                if (!end_of_input && char_in == ntt_pkg::CH_STAR) begin
                    state_next = ntt_pkg::ST_BLK;
                end else begin
                    // held-back slash becomes the first word byte
                    bundle.res[n] = mk(ntt_pkg::KIND_BYTE, ntt_pkg::CH_SLASH, 1'b0);
                    n = n + 2'd1;
                    state_next = ntt_pkg::ST_WORD;
                    if (ender) begin
                        bundle.res[n] = mk(ntt_pkg::KIND_END, 8'h00, dot);
                        n = n + 2'd1;
                        dot_next = 1'b0;
                        do_idle  = 1'b1;
                    end else begin
                        bundle.res[n] = mk(ntt_pkg::KIND_BYTE, char_in, 1'b0);
                        n = n + 2'd1;
                    end
                end
            end
            default: begin
                do_idle = 1'b1;
            end
        endcase

        if (do_idle) begin
            state_next = ntt_pkg::ST_IDLE;
            if (end_of_input) begin
                bundle.res[n] = mk(ntt_pkg::KIND_EOF, 8'h00, 1'b0);
                n = n + 2'd1;
            end else begin
                unique case (char_in)
                    ntt_pkg::CH_SPACE, ntt_pkg::CH_TAB: begin
                    end
                    ntt_pkg::CH_NL: begin
                        bundle.res[n] = mk(ntt_pkg::KIND_NL, 8'h00, 1'b0);
                        n = n + 2'd1;
                    end
                    ntt_pkg::CH_EQ: begin
                        bundle.res[n] = mk(ntt_pkg::KIND_EQ, 8'h00, 1'b0);
                        n = n + 2'd1;
                    end
                    ntt_pkg::CH_DOT: begin
                        dot_next   = 1'b1;
                        state_next = ntt_pkg::ST_WORD;
                    end
                    ntt_pkg::CH_HASH:  state_next = ntt_pkg::ST_HASH;
                    ntt_pkg::CH_SLASH: state_next = ntt_pkg::ST_SLASH;
                    ntt_pkg::CH_BSL:   state_next = ntt_pkg::ST_BSL;
                    default: begin
                        bundle.res[n] = mk(ntt_pkg::KIND_BYTE, char_in, 1'b0);
                        n = n + 2'd1;
                        state_next = ntt_pkg::ST_WORD;
                    end
                endcase
            end
        end

        bundle.cnt = n;
    end

endmodule

`default_nettype wire

### rtl/netlist_text_tokenizer.sv
// A byte's first token is on m_* in the cycle after its transfer. Throughput:
// one byte per cycle while each byte yields at most one token and m_tready is
// high; a byte that yields k tokens (k up to 3) holds off the next byte until
// its last token leaves the single result buffer, which drains one token per
// cycle while m_tready is high. Reset: synchronous, active low; scanner goes
// idle, dot flag clears, buffer empties.
// ----------------------------------------------------------------------------
// Netlist text tokenizer
// Byte-stream lexer producing word-byte, word-end, newline, equals and EOF.
// ----------------------------------------------------------------------------
`default_nettype none

`include "netlist_text_tokenizer_assert.svh"

module netlist_text_tokenizer (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] char_in
    input  wire logic       s_tuser,   // [0] end_of_input
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] word_byte
    output logic [3:0]      m_tuser,   // [2:0] kind, [3] dot_word
    output logic            m_tlast
);

    ntt_pkg::state_t  state_reg, state_next;
    logic             dot_reg, dot_next;
    ntt_pkg::bundle_t step_bundle;
    ntt_pkg::bundle_t bnd_reg;
    logic [1:0]       idx_reg;
    logic             vld_reg;
    ntt_pkg::result_t cur;
    logic             s_xfer, m_xfer, drain_last;
    logic             bnd_load;

    ntt_step u_step (
        .state        (state_reg),
        .dot          (dot_reg),
        .char_in      (s_tdata),
        .end_of_input (s_tuser),
        .state_next   (state_next),
        .dot_next     (dot_next),
        .bundle       (step_bundle)
    );

    assign cur        = bnd_reg.res[idx_reg];
    assign m_tvalid   = vld_reg;
    assign m_tdata    = cur.word_byte;
    assign m_tuser    = {cur.dot_word, cur.kind};
    assign m_tlast    = (idx_reg == bnd_reg.cnt - 2'd1);
    assign m_xfer     = vld_reg && m_tready;
    assign drain_last = m_xfer && m_tlast;
    assign s_tready   = !vld_reg || drain_last;
    assign s_xfer     = s_tvalid && s_tready;
    assign bnd_load   = s_xfer && step_bundle.cnt != 2'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ntt_pkg::ST_IDLE;
            dot_reg   <= 1'b0;
            vld_reg   <= 1'b0;
            idx_reg   <= 2'd0;
        end else begin
            if (s_xfer) begin
                state_reg <= state_next;
                dot_reg   <= dot_next;
            end
            if (bnd_load) begin
                vld_reg <= 1'b1;
                idx_reg <= 2'd0;
            end else if (drain_last) begin
                vld_reg <= 1'b0;
            end else if (m_xfer) begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (bnd_load) begin
            bnd_reg <= step_bundle;
        end
    end

    `NTT_ASSERT(a_idx_in_range, aclk, aresetn, !vld_reg || (idx_reg < bnd_reg.cnt))
    `NTT_ASSERT(a_ready_when_empty, aclk, aresetn, vld_reg || s_tready)
    `NTT_ASSERT_NEXT(a_load_starts, aclk, aresetn, bnd_load, vld_reg && idx_reg == 2'd0)

endmodule

`default_nettype wire
